// File: rtl/plvt_pkg.sv
// ----------------------------------------------------------------------------
// plvt_pkg
// Shared types and constants of the page/line version table: table geometry,
// operation codes, transfer payloads and the stored page and line entries.
// ----------------------------------------------------------------------------
`default_nettype none

package plvt_pkg;

   // table geometry
   localparam int NUM_PAGES      = 1024;
   localparam int LINES_PER_PAGE = 64;
   localparam int HANDLE_BITS    = 16;

   // field widths of the transfers
   localparam int PAGE_IDX_W = 10;
   localparam int LINE_IDX_W = 6;
   localparam int VER_W      = 32;
   localparam int HND_IN_W   = 16;
   localparam int HIST_W     = 8;

   // derived widths
   localparam int PAGE_BITS = $clog2(NUM_PAGES);
   localparam int LINE_BITS = $clog2(LINES_PER_PAGE);
   localparam int SLOT_BITS = PAGE_BITS + LINE_BITS;
   localparam int SLOT_DEPTH = 1 << SLOT_BITS;
   localparam int HND_W = (HANDLE_BITS < HND_IN_W) ? HANDLE_BITS : HND_IN_W;

   // operation codes
   typedef enum logic [2:0] {
      OP_SET_COMMITTED = 3'd0,
      OP_WAIT_CHECK    = 3'd1,
      OP_DIFF_BIT      = 3'd2,
      OP_MERGE_BIT     = 3'd3,
      OP_ENABLE_LOG    = 3'd4,
      OP_RECORD        = 3'd5,
      OP_LOOKUP        = 3'd6,
      OP_CLEAR_LINE    = 3'd7
   } op_type;

   // request transfer
   typedef struct packed {
      op_type                  operation;
      logic [PAGE_IDX_W-1:0]   page_num;
      logic [LINE_IDX_W-1:0]   line_num;
      logic [VER_W-1:0]        version;
      logic [HND_IN_W-1:0]     entry_handle;
      logic                    full_page;
      logic                    history_bit;
      logic                    page_level;
   } req_type;

   // response transfer
   typedef struct packed {
      logic                    wait_safe;
      logic                    is_logging;
      logic [HIST_W-1:0]       diff_history;
      logic [HIST_W-1:0]       merge_history;
      logic                    found;
      logic [HND_IN_W-1:0]     result_handle;
      logic [VER_W-1:0]        result_version;
      logic                    page_is_newest;
   } rsp_type;

   // one page entry of the page memory
   typedef struct packed {
      logic [VER_W-1:0]          committed;
      logic [HIST_W-1:0]         diff_hist;
      logic [HIST_W-1:0]         merge_hist;
      logic                      logging_on;
      logic [VER_W-1:0]          whole_version;
      logic [VER_W-1:0]          newest_version;
      logic [HND_W-1:0]          whole_handle;
      logic [LINES_PER_PAGE-1:0] line_valid;
   } page_entry_type;

   // one line entry of the line memory
   typedef struct packed {
      logic [VER_W-1:0] version;
      logic [HND_W-1:0] handle;
   } line_entry_type;

endpackage

`default_nettype wire

// File: rtl/page_line_version_table_top.sv
// ----------------------------------------------------------------------------
// page_line_version_table_top
// Per-page version table with committed versions, outcome histories and a
// per-page logging store of whole-page and per-line versions and handles.
// ----------------------------------------------------------------------------
// On a request transfer the reads of the page memory and the line memory
// are launched; in the work state the block then modifies the page entry,
// writes it back and loads the response register. A new request is
// taken once the previous one has been written back, even while its
// response still waits on rsp_stall; the write-back itself waits only while
// the response register is full and stalled. After reset the page memory is
// swept to zero, one page per cycle, over all NUM_PAGES pages (1024 here);
// req_stall stays high during that pass.
`default_nettype none

module page_line_version_table_top (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  plvt_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output plvt_pkg::rsp_type   rsp_data
);
   import plvt_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_WORK  = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [PAGE_BITS-1:0]   clr_ff, clr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   req_type                req_q_ff;
   page_entry_type         pg_rd_ff;
   line_entry_type         ln_rd_ff;

   page_entry_type         pg_mem [NUM_PAGES];
   line_entry_type         ln_mem [SLOT_DEPTH];

   logic                   req_xfer;
   logic                   work_fire;
   logic [PAGE_BITS-1:0]   rd_page;
   logic [SLOT_BITS-1:0]   rd_slot;

   logic                   pg_we;
   logic [PAGE_BITS-1:0]   pg_waddr;
   page_entry_type         pg_wdata;
   logic                   ln_we;
   logic [SLOT_BITS-1:0]   ln_waddr;
   line_entry_type         ln_wdata;

   logic                   page_ok;
   logic                   line_ok;
   logic [LINE_BITS-1:0]   lidx;
   logic [HND_W-1:0]       hnd;
   logic                   lvalid;
   logic [VER_W-1:0]       lv;
   logic [HND_W-1:0]       lh;
   logic [HND_W-1:0]       rh;
   logic [VER_W-1:0]       rv;
   logic                   ws;
   page_entry_type         pe_new;

   // request side handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign work_fire = (state_ff == ST_WORK) && (!rsp_valid_ff || !rsp_stall);

   // read addresses straight from the request port
   assign rd_page = PAGE_BITS'(req_data.page_num);
   assign rd_slot = {rd_page, req_data.line_num[LINE_BITS-1:0]};

   // decode of the captured request
   assign page_ok = {1'b0, req_q_ff.page_num} < (PAGE_IDX_W+1)'(NUM_PAGES);
   assign line_ok = {1'b0, req_q_ff.line_num} < (LINE_IDX_W+1)'(LINES_PER_PAGE);
   assign lidx    = req_q_ff.line_num[LINE_BITS-1:0];
   assign hnd     = HND_W'(req_q_ff.entry_handle);
   assign lvalid  = line_ok && pg_rd_ff.line_valid[lidx];
   assign lv      = lvalid ? ln_rd_ff.version : '0;
   assign lh      = lvalid ? ln_rd_ff.handle : '0;

   // read-modify of the page entry and response build
   always_comb begin
      pe_new   = pg_rd_ff;
      ws       = 1'b0;
      rh       = '0;
      rv       = '0;
      ln_we    = 1'b0;
      ln_waddr = {PAGE_BITS'(req_q_ff.page_num), lidx};
      ln_wdata.version = req_q_ff.version;
      ln_wdata.handle  = hnd;
      case (req_q_ff.operation)
         OP_SET_COMMITTED: begin
            pe_new.committed = req_q_ff.version;
         end
         OP_WAIT_CHECK: begin
            ws = (pg_rd_ff.committed >= req_q_ff.version);
         end
         OP_DIFF_BIT: begin
            pe_new.diff_hist = {pg_rd_ff.diff_hist[HIST_W-2:0], req_q_ff.history_bit};
         end
         OP_MERGE_BIT: begin
            pe_new.merge_hist = {pg_rd_ff.merge_hist[HIST_W-2:0], req_q_ff.history_bit};
         end
         OP_ENABLE_LOG: begin
            pe_new.logging_on     = 1'b1;
            pe_new.whole_version  = '0;
            pe_new.newest_version = '0;
            pe_new.whole_handle   = '0;
            pe_new.line_valid     = '0;
         end
         OP_RECORD: begin
            if (pg_rd_ff.logging_on) begin
               if (req_q_ff.full_page) begin
                  pe_new.whole_version  = req_q_ff.version;
                  pe_new.whole_handle   = hnd;
                  pe_new.newest_version = req_q_ff.version;
               end else if (line_ok) begin
                  ln_we = page_ok;
                  pe_new.line_valid[lidx] = 1'b1;
                  pe_new.newest_version   = req_q_ff.version;
               end
            end
         end
         OP_LOOKUP: begin
            if (pg_rd_ff.logging_on) begin
               if (req_q_ff.page_level) begin
                  if (pg_rd_ff.whole_version == pg_rd_ff.newest_version) begin
                     rh = pg_rd_ff.whole_handle;
                     rv = pg_rd_ff.whole_version;
                  end else begin
                     rv = pg_rd_ff.newest_version;
                  end
               end else if (line_ok) begin
                  if (pg_rd_ff.whole_version > lv) begin
                     rh = pg_rd_ff.whole_handle;
                     rv = pg_rd_ff.whole_version;
                  end else begin
                     rh = lh;
                     rv = lv;
                  end
               end
            end
         end
         default: begin
            if (pg_rd_ff.logging_on && line_ok) begin
               pe_new.line_valid[lidx] = 1'b0;
            end
         end
      endcase
   end

   // page memory write port: clearing pass or write-back
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         pg_we    = 1'b1;
         pg_waddr = clr_ff;
         pg_wdata = '0;
      end else begin
         pg_we    = work_fire && page_ok;
         pg_waddr = PAGE_BITS'(req_q_ff.page_num);
         pg_wdata = pe_new;
      end
   end

   // next response
   always_comb begin
      rsp_data_in = '0;
      if (page_ok) begin
         rsp_data_in.wait_safe      = ws;
         rsp_data_in.is_logging     = pe_new.logging_on;
         rsp_data_in.diff_history   = pe_new.diff_hist;
         rsp_data_in.merge_history  = pe_new.merge_hist;
         rsp_data_in.found          = (rh != '0);
         rsp_data_in.result_handle  = HND_IN_W'(rh);
         rsp_data_in.result_version = rv;
         rsp_data_in.page_is_newest = pe_new.logging_on &&
                                      (pe_new.whole_version == pe_new.newest_version);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + PAGE_BITS'(1);
            if (clr_ff == PAGE_BITS'(NUM_PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            if (work_fire) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_q_ff <= req_data;
      end
      if (work_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // page memory
   always_ff @(posedge clock) begin
      if (pg_we) begin
         pg_mem[pg_waddr] <= pg_wdata;
      end
      if (req_xfer) begin
         pg_rd_ff <= pg_mem[rd_page];
      end
   end

   // line memory
   always_ff @(posedge clock) begin
      if (ln_we && work_fire) begin
         ln_mem[ln_waddr] <= ln_wdata;
      end
      if (req_xfer) begin
         ln_rd_ff <= ln_mem[rd_slot];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: rtl/plvt_checker.sv
// ----------------------------------------------------------------------------
// plvt_checker
// Port-level checks of the page/line version table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module plvt_checker (
   input wire                 clock,
   input wire                 reset,
   input wire                 req_valid,
   input wire                 req_stall,
   input wire                 rsp_valid,
   input wire                 rsp_stall,
   input plvt_pkg::rsp_type   rsp_data
);
   import plvt_pkg::*;

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // one request in flight: stall right after a request transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // found follows the returned handle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.found == (rsp_data.result_handle != '0)))
      else $error("found does not match result handle");

   // a page that is not logging reports no lookup result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_logging |->
         !rsp_data.found && !rsp_data.page_is_newest && (rsp_data.result_version == '0))
      else $error("non-logging page returned lookup data");

   // wait check and lookup results never show together
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.wait_safe && rsp_data.found))
      else $error("wait_safe and found both set");

endmodule

bind page_line_version_table_top plvt_checker u_plvt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// File: tb/page_line_version_table_top_test.sv
// ----------------------------------------------------------------------------
// page_line_version_table_top_test
// Self-checking bench for the page/line version table. A driver feeds table
// accesses from a queue; each accepted access runs through a mirror of the
// page and line store that computes the answer the block must give. The
// monitor compares every response transfer field by field against the
// oldest pending answer. Both channels idle at random; the response side
// also holds off for a long stretch and the request side drains twice.
// ----------------------------------------------------------------------------
`default_nettype none

module page_line_version_table_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import plvt_pkg::*;

   localparam int ACCESS_COUNT    = 1250;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = 20;
   localparam int HOLD_OFF_AT     = 500;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOT_PAGES       = 8;
   localparam int REPORT_LIMIT    = 200;
   localparam logic [HND_IN_W-1:0] HANDLE_MASK =
      HND_IN_W'((64'd1 << HANDLE_BITS) - 64'd1);

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // mirror of the page store
   bit [VER_W-1:0]          page_committed [NUM_PAGES];
   bit [HIST_W-1:0]         page_diff_hist [NUM_PAGES];
   bit [HIST_W-1:0]         page_merge_hist [NUM_PAGES];
   bit                      page_logging [NUM_PAGES];
   bit [VER_W-1:0]          page_whole_ver [NUM_PAGES];
   bit [VER_W-1:0]          page_newest_ver [NUM_PAGES];
   bit [HND_IN_W-1:0]       page_whole_hnd [NUM_PAGES];
   bit [LINES_PER_PAGE-1:0] page_line_valid [NUM_PAGES];

   // mirror of the line store
   bit [VER_W-1:0]    line_ver [SLOT_DEPTH];
   bit [HND_IN_W-1:0] line_hnd [SLOT_DEPTH];

   req_type access_queue [$];
   bit      access_drain [$];
   rsp_type table_answers [$];
   rsp_type answer;

   int accepted_count = 0;
   int received_count = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int req_gap        = 0;
   int rsp_gap        = 0;
   bit pause_pending  = 1'b0;

   page_line_version_table_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // apply one access to the mirror and return the answer it produces
   function automatic rsp_type table_access(req_type r);
      rsp_type           a;
      int                p;
      int                slot;
      bit                line_ok;
      bit [VER_W-1:0]    lv;
      bit [HND_IN_W-1:0] lh;
      bit [HND_IN_W-1:0] hnd;
      a = '0;
      if (r.page_num >= NUM_PAGES) return a;
      p       = r.page_num;
      line_ok = r.line_num < LINES_PER_PAGE;
      slot    = p * LINES_PER_PAGE + (line_ok ? r.line_num : 0);
      hnd     = r.entry_handle & HANDLE_MASK;
      case (r.operation)
         OP_SET_COMMITTED: page_committed[p] = r.version;
         OP_WAIT_CHECK:    a.wait_safe = page_committed[p] >= r.version;
         OP_DIFF_BIT:      page_diff_hist[p] = {page_diff_hist[p][HIST_W-2:0], r.history_bit};
         OP_MERGE_BIT:     page_merge_hist[p] = {page_merge_hist[p][HIST_W-2:0], r.history_bit};
         OP_ENABLE_LOG: begin
            page_logging[p]    = 1'b1;
            page_whole_ver[p]  = '0;
            page_newest_ver[p] = '0;
            page_whole_hnd[p]  = '0;
            page_line_valid[p] = '0;
         end
         OP_RECORD: begin
            if (page_logging[p]) begin
               if (r.full_page) begin
                  page_whole_ver[p]  = r.version;
                  page_whole_hnd[p]  = hnd;
                  page_newest_ver[p] = r.version;
               end else if (line_ok) begin
                  line_ver[slot] = r.version;
                  line_hnd[slot] = hnd;
                  page_line_valid[p][r.line_num] = 1'b1;
                  page_newest_ver[p] = r.version;
               end
            end
         end
         OP_LOOKUP: begin
            if (page_logging[p]) begin
               if (r.page_level) begin
                  if (page_whole_ver[p] == page_newest_ver[p]) begin
                     a.result_handle  = page_whole_hnd[p];
                     a.result_version = page_whole_ver[p];
                  end else begin
                     a.result_version = page_newest_ver[p];
                  end
               end else if (line_ok) begin
                  // an invalid line reads as version 0, handle 0
                  lv = page_line_valid[p][r.line_num] ? line_ver[slot] : '0;
                  lh = page_line_valid[p][r.line_num] ? line_hnd[slot] : '0;
                  if (page_whole_ver[p] > lv) begin
                     a.result_handle  = page_whole_hnd[p];
                     a.result_version = page_whole_ver[p];
                  end else begin
                     a.result_handle  = lh;
                     a.result_version = lv;
                  end
               end
               a.found = a.result_handle != '0;
            end
         end
         OP_CLEAR_LINE: begin
            if (page_logging[p] && line_ok) page_line_valid[p][r.line_num] = 1'b0;
         end
         default: ;
      endcase
      a.is_logging     = page_logging[p];
      a.diff_history   = page_diff_hist[p];
      a.merge_history  = page_merge_hist[p];
      a.page_is_newest = page_logging[p] && page_whole_ver[p] == page_newest_ver[p];
      return a;
   endfunction

   // idle cycles before the next transfer; every third stretch runs flat out
   function automatic int draw_gap(int n);
      if ((n / 150) % 3 == 1) return 0;
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(1, 18);
   endfunction

   function automatic logic [VER_W-1:0] pick_version(logic [VER_W-1:0] near);
      case ($urandom_range(0, 7))
         0:       return $urandom();
         1:       return '1;
         2:       return '0;
         3:       return near;
         default: return near + $urandom_range(0, 3);
      endcase
   endfunction

   function automatic logic [HND_IN_W-1:0] pick_handle();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom_range(1, 15);
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_access(op_type op, int page, int line, logic [VER_W-1:0] ver,
                               logic [HND_IN_W-1:0] hnd, bit full, bit hbit, bit plevel);
      req_type r;
      r.operation    = op;
      r.page_num     = PAGE_IDX_W'(page);
      r.line_num     = LINE_IDX_W'(line);
      r.version      = ver;
      r.entry_handle = hnd;
      r.full_page    = full;
      r.history_bit  = hbit;
      r.page_level   = plevel;
      access_queue.push_back(r);
      access_drain.push_back(pause_pending);
      pause_pending = 1'b0;
   endtask

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         // keep the log short when the block is badly off
         if (mismatch_count < REPORT_LIMIT)
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // request driver: predicts each accepted access, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            table_answers.push_back(table_access(req_data));
            accepted_count++;
            req_gap = draw_gap(accepted_count);
         end
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (access_queue.size() != 0 &&
                      !(access_drain[0] && table_answers.size() != 0)) begin
            req_data <= access_queue.pop_front();
            void'(access_drain.pop_front());
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor: checks each transfer and paces rsp_stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            received_count++;
            if (table_answers.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("%0t: response with none pending, expected none, actual 0x%0h",
                           $time, rsp_data);
               mismatch_count++;
            end else begin
               answer = table_answers.pop_front();
               compare_field("wait_safe", answer.wait_safe, rsp_data.wait_safe);
               compare_field("is_logging", answer.is_logging, rsp_data.is_logging);
               compare_field("diff_history", answer.diff_history, rsp_data.diff_history);
               compare_field("merge_history", answer.merge_history, rsp_data.merge_history);
               compare_field("found", answer.found, rsp_data.found);
               compare_field("result_handle", answer.result_handle, rsp_data.result_handle);
               compare_field("result_version", answer.result_version, rsp_data.result_version);
               compare_field("page_is_newest", answer.page_is_newest, rsp_data.page_is_newest);
            end
            // one long hold-off lets the block fill up and stall its input
            rsp_gap = (received_count == HOLD_OFF_AT) ? HOLD_OFF_CYCLES
                                                      : draw_gap(received_count);
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int             hot_page [HOT_PAGES];
      logic [VER_W-1:0] hot_clock [HOT_PAGES];
      int             random_count;
      int             k;
      int             burst;
      int             pick;
      int             line;
      bit             mid_pause_done;
      op_type         op;
      logic [VER_W-1:0] ver;

      // directed: untouched page, committed extremes and histories
      queue_access(OP_WAIT_CHECK, 0, 0, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
      queue_access(OP_WAIT_CHECK, 0, 0, 32'd1, 16'd0, 1'b0, 1'b0, 1'b0);
      queue_access(OP_SET_COMMITTED, NUM_PAGES - 1, 63, '1, '1, 1'b1, 1'b1, 1'b1);
      queue_access(OP_WAIT_CHECK, NUM_PAGES - 1, 63, '1, '1, 1'b1, 1'b1, 1'b1);
      queue_access(OP_DIFF_BIT, NUM_PAGES - 1, 0, 32'd0, 16'd0, 1'b0, 1'b1, 1'b0);
      queue_access(OP_MERGE_BIT, NUM_PAGES - 1, 0, 32'd0, 16'd0, 1'b0, 1'b1, 1'b0);
      // logging store accesses on a page that is not logging are ignored
      queue_access(OP_RECORD, 5, 3, 32'd7, 16'd9, 1'b0, 1'b0, 1'b0);
      queue_access(OP_LOOKUP, 5, 3, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
      queue_access(OP_CLEAR_LINE, 5, 3, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
      // logging page: line, whole-page and page-level lookups
      queue_access(OP_ENABLE_LOG, 5, 0, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
      queue_access(OP_LOOKUP, 5, 0, 32'd0, 16'd0, 1'b0, 1'b0, 1'b1);
      queue_access(OP_RECORD, 5, 63, 32'd10, '1, 1'b0, 1'b0, 1'b0);
      queue_access(OP_LOOKUP, 5, 63, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
      queue_access(OP_LOOKUP, 5, 63, 32'd0, 16'd0, 1'b0, 1'b0, 1'b1);
      queue_access(OP_RECORD, 5, 0, 32'd20, 16'd1, 1'b1, 1'b0, 1'b0);
      queue_access(OP_LOOKUP, 5, 63, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
      queue_access(OP_LOOKUP, 5, 0, 32'd0, 16'd0, 1'b0, 1'b0, 1'b1);
      queue_access(OP_RECORD, 5, 0, '1, 16'd0, 1'b0, 1'b0, 1'b0);
      queue_access(OP_LOOKUP, 5, 0, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
      queue_access(OP_CLEAR_LINE, 5, 63, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
      queue_access(OP_LOOKUP, 5, 63, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
      // enabling an already logging page clears its store again
      queue_access(OP_ENABLE_LOG, 5, 0, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
      queue_access(OP_LOOKUP, 5, 0, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
      // wait check compares unsigned
      queue_access(OP_SET_COMMITTED, 5, 0, 32'h8000_0000, 16'd0, 1'b0, 1'b0, 1'b0);
      queue_access(OP_WAIT_CHECK, 5, 0, 32'h7fff_ffff, 16'd0, 1'b0, 1'b0, 1'b0);

      // random: bursts on a few hot pages, with some noise over all pages
      for (k = 0; k < HOT_PAGES; k++) begin
         hot_page[k]  = $urandom_range(0, NUM_PAGES - 1);
         hot_clock[k] = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 50);
      end
      random_count   = 0;
      mid_pause_done = 1'b0;
      pause_pending  = 1'b1;
      while (random_count < ACCESS_COUNT) begin
         if (!mid_pause_done && random_count >= ACCESS_COUNT / 2) begin
            pause_pending  = 1'b1;
            mid_pause_done = 1'b1;
         end
         if ($urandom_range(0, 9) < 8) begin
            k = $urandom_range(0, HOT_PAGES - 1);
            if ($urandom_range(0, 4) == 0) begin
               queue_access(OP_ENABLE_LOG, hot_page[k], $urandom_range(0, 63), $urandom(),
                            $urandom(), $urandom_range(0, 1), $urandom_range(0, 1),
                            $urandom_range(0, 1));
               random_count++;
            end
            burst = $urandom_range(4, 16);
            repeat (burst) begin
               ver  = pick_version(hot_clock[k]);
               line = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                           : $urandom_range(0, LINES_PER_PAGE - 1);
               pick = $urandom_range(0, 19);
               if (pick < 7) begin
                  op = OP_RECORD;
                  hot_clock[k] = ver;
               end else if (pick < 14) begin
                  op = OP_LOOKUP;
               end else if (pick < 16) begin
                  op = OP_CLEAR_LINE;
               end else begin
                  op = op_type'($urandom_range(0, 3));
               end
               queue_access(op, hot_page[k], line, ver, pick_handle(),
                            $urandom_range(0, 2) == 0, $urandom_range(0, 1),
                            $urandom_range(0, 2) == 0);
               random_count++;
            end
         end else begin
            op = op_type'($urandom_range(0, 7));
            queue_access(op, $urandom_range(0, NUM_PAGES - 1), $urandom_range(0, 63),
                         $urandom(), $urandom(), $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1));
            // store accesses to a random page mostly land on a page that is not logging
            if (op != OP_RECORD && op != OP_CLEAR_LINE) random_count++;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (access_queue.size() != 0 || req_valid) @(posedge clock);
      while (table_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
